// ===== src/cnz_pkg.sv =====
// Package with constants and types shared by the cellular noise unit.
`default_nettype none
package cnz_pkg;
   localparam int FracBitsDefault = 16;
   localparam int NoiseWidth = 18;
   localparam logic [31:0] HashMulX = 32'h37476139;
   localparam logic [31:0] HashMulY = 32'h68265263;
   localparam logic [31:0] MixMulA = 32'h85ebca6b;
   localparam logic [31:0] MixMulB = 32'hc2b2ae35;
   localparam logic [31:0] OffsetX2 = 32'd123;
   localparam logic [31:0] OffsetY2 = 32'd456;
   localparam int NumCells = 9;
   localparam int NumHashes = 18;
endpackage
`default_nettype wire

// ===== src/cnz_hash.sv =====
// Pipelined murmur-style cell hash: five register stages; multiplies in the first, third and fourth.
`default_nettype none
module cnz_hash #(
   parameter int FRAC_BITS = cnz_pkg::FracBitsDefault
) (
   input  wire logic                 clock,
   input  wire logic                 enable,
   input  wire logic [31:0]          cell_x,
   input  wire logic [31:0]          cell_y,
   output logic      [FRAC_BITS-1:0] hash_frac
);
   import cnz_pkg::*;
   logic [31:0] px_ff, py_ff, s1_ff, s2_ff, s3_ff, s4_ff;
   logic [31:0] s1_in, s2_in, s3_in, s4_in;

   assign s1_in = px_ff + py_ff;
   assign s2_in = (s1_ff ^ (s1_ff >> 16)) * MixMulA;
   assign s3_in = (s2_ff ^ (s2_ff >> 13)) * MixMulB;
   assign s4_in = s3_ff ^ (s3_ff >> 16);

   always_ff @(posedge clock) begin
      if (enable) begin
         px_ff <= cell_x * HashMulX;
         py_ff <= cell_y * HashMulY;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   assign hash_frac = s4_ff[30 -: FRAC_BITS];
endmodule
`default_nettype wire

// ===== src/cnz_sqrt.sv =====
// Pipelined integer square root, two result bits resolved per stage.
`default_nettype none
module cnz_sqrt #(
   parameter int IN_W = 40,
   parameter int OUT_W = 20
) (
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire logic [IN_W-1:0]  radicand,
   output logic      [OUT_W-1:0] root
);
   localparam int StepsPerStage = 2;
   localparam int NumStages = (OUT_W + StepsPerStage - 1) / StepsPerStage;
   localparam int PadW = 2 * NumStages * StepsPerStage;

   logic [PadW-1:0]  rad_ff [NumStages+1];
   logic [OUT_W+1:0] rem_ff [NumStages+1];
   logic [OUT_W-1:0] res_ff [NumStages+1];

   always_comb begin
      rad_ff[0] = PadW'(radicand);
      rem_ff[0] = '0;
      res_ff[0] = '0;
   end

   for (genvar s = 0; s < NumStages; s++) begin : g_stage
      logic [PadW-1:0]  rad_in;
      logic [OUT_W+1:0] rem_in;
      logic [OUT_W-1:0] res_in;
      always_comb begin
         logic [OUT_W+1:0] trial;
         logic [OUT_W+1:0] rem_v;
         logic [OUT_W-1:0] res_v;
         logic [PadW-1:0]  rad_v;
         rem_v = rem_ff[s];
         res_v = res_ff[s];
         rad_v = rad_ff[s];
         for (int k = 0; k < StepsPerStage; k++) begin
            rem_v = {rem_v[OUT_W-1:0], rad_v[PadW-1 -: 2]};
            rad_v = rad_v << 2;
            trial = {res_v, 2'b01};
            if (rem_v >= trial) begin
               rem_v = rem_v - trial;
               res_v = {res_v[OUT_W-2:0], 1'b1};
            end else begin
               res_v = {res_v[OUT_W-2:0], 1'b0};
            end
         end
         rad_in = rad_v;
         rem_in = rem_v;
         res_in = res_v;
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rad_ff[s+1] <= rad_in;
            rem_ff[s+1] <= rem_in;
            res_ff[s+1] <= res_in;
         end
      end
   end

   assign root = res_ff[NumStages];
endmodule
`default_nettype wire

// ===== src/cnz_sort.sv =====
// Distance evaluation for nine cells and a registered sort into nearest and second nearest.
`default_nettype none
module cnz_sort #(
   parameter int FRAC_BITS = cnz_pkg::FracBitsDefault
) (
   input  wire logic                      clock,
   input  wire logic                      enable,
   input  wire logic [FRAC_BITS-1:0]      frac_x,
   input  wire logic [FRAC_BITS-1:0]      frac_y,
   input  wire logic [FRAC_BITS-1:0]      hash_x [cnz_pkg::NumCells],
   input  wire logic [FRAC_BITS-1:0]      hash_y [cnz_pkg::NumCells],
   output logic      [2*FRAC_BITS+3:0]    dist_f1,
   output logic      [2*FRAC_BITS+3:0]    dist_f2
);
   import cnz_pkg::*;
   localparam int DW = FRAC_BITS + 2;      // signed delta in (-2, 2)
   localparam int SW = 2 * FRAC_BITS + 4;  // squared sum up to 8.0

   logic signed [DW-1:0]   dx_ff [NumCells];
   logic signed [DW-1:0]   dy_ff [NumCells];
   logic        [SW-1:0]   sx_ff [NumCells];
   logic        [SW-1:0]   sy_ff [NumCells];
   logic        [SW-1:0]   d_ff  [NumCells];
   logic        [SW-1:0]   a1_ff, a2_ff, b1_ff, b2_ff, c1_ff, c2_ff;
   logic        [SW-1:0]   a1_in, a2_in, b1_in, b2_in, c1_in, c2_in;
   logic        [SW-1:0]   f1_in, f2_in;

   // Merge one distance into a running pair of smallest values.
   function automatic logic [2*SW-1:0] ins(input logic [SW-1:0] m1, input logic [SW-1:0] m2,
                                           input logic [SW-1:0] d);
      logic [SW-1:0] n1, n2;
      n1 = m1;
      n2 = m2;
      if (d < m1) begin
         n2 = m1;
         n1 = d;
      end else if (d < m2) begin
         n2 = d;
      end
      return {n2, n1};
   endfunction

   // Merge two sorted pairs; ties keep the first pair's value first.
   function automatic logic [2*SW-1:0] mrg(input logic [SW-1:0] p1, input logic [SW-1:0] p2,
                                           input logic [SW-1:0] q1, input logic [SW-1:0] q2);
      logic [SW-1:0] n1, n2;
      if (q1 < p1) begin
         n1 = q1;
         n2 = (q2 < p1) ? q2 : p1;
      end else begin
         n1 = p1;
         n2 = (q1 < p2) ? q1 : p2;
      end
      return {n2, n1};
   endfunction

   for (genvar c = 0; c < NumCells; c++) begin : g_cell
      localparam logic signed [DW-1:0] OffU = DW'((c % 3) - 1) <<< FRAC_BITS;
      localparam logic signed [DW-1:0] OffV = DW'((c / 3) - 1) <<< FRAC_BITS;
      // Full-width signed squares of the deltas.
      logic signed [2*DW-1:0] sqx, sqy;
      assign sqx = dx_ff[c] * dx_ff[c];
      assign sqy = dy_ff[c] * dy_ff[c];
      always_ff @(posedge clock) begin
         if (enable) begin
            dx_ff[c] <= OffU + signed'(DW'(hash_x[c])) - signed'(DW'(frac_x));
            dy_ff[c] <= OffV + signed'(DW'(hash_y[c])) - signed'(DW'(frac_y));
            sx_ff[c] <= SW'(unsigned'(sqx));
            sy_ff[c] <= SW'(unsigned'(sqy));
            d_ff[c]  <= sx_ff[c] + sy_ff[c];
         end
      end
   end

   // Scan order of the model: the three rows are each sorted, then merged in order.
   always_comb begin
      {a2_in, a1_in} = ins(d_ff[0], {SW{1'b1}}, d_ff[1]);
      {a2_in, a1_in} = ins(a1_in, a2_in, d_ff[2]);
      {b2_in, b1_in} = ins(d_ff[3], {SW{1'b1}}, d_ff[4]);
      {b2_in, b1_in} = ins(b1_in, b2_in, d_ff[5]);
      {c2_in, c1_in} = ins(d_ff[6], {SW{1'b1}}, d_ff[7]);
      {c2_in, c1_in} = ins(c1_in, c2_in, d_ff[8]);
      {f2_in, f1_in} = mrg(a1_ff, a2_ff, b1_ff, b2_ff);
      {f2_in, f1_in} = mrg(f1_in, f2_in, c1_ff, c2_ff);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a1_ff <= a1_in;
         a2_ff <= a2_in;
         b1_ff <= b1_in;
         b2_ff <= b2_in;
         c1_ff <= c1_in;
         c2_ff <= c2_in;
         dist_f1 <= f1_in;
         dist_f2 <= f2_in;
      end
   end
endmodule
`default_nettype wire

// ===== src/cellular_noise_2d_unit.sv =====
// Top level of the 2D cellular noise unit: hashing, distance sort and root pipeline.
`default_nettype none
//  Channel   Direction  Payload
//  req_      in         tdata[31:0] x_coord, tdata[63:32] y_coord
//  rsp_      out        tdata[17:0] noise_value (six zero bits above)
//  csr_      in         wdata[0] mode
//
// One transfer can be taken in every cycle while the pipeline is not stalled.
// The path runs through the cell index stage, five hash stages, five distance
// and sort stages and the square root stages (half the root width, nine by
// default), plus the output register: 21 register stages.
// The whole pipeline advances together; when rsp_tready is low and the
// output holds a result, every stage holds, so nothing is lost or repeated.
// Reset clears the valid bits and sets mode to one; data registers keep
// whatever they held.
module cellular_noise_2d_unit #(
   parameter int FRAC_BITS = cnz_pkg::FracBitsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // x_coord [31:0], y_coord [63:32]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // noise_value [17:0], zero fill above
   input  wire logic        csr_wen,
   input  wire logic        csr_wdata
);
   import cnz_pkg::*;
   localparam int SW = 2 * FRAC_BITS + 4;
   localparam int RW = FRAC_BITS + 2;
   localparam int HashLat = 5;
   localparam int SortLat = 5;
   localparam int SqrtLat = (RW + 1) / 2;
   localparam int Lat = 1 + HashLat + SortLat + SqrtLat;
   localparam logic [RW-1:0] OneVal = RW'(1) << FRAC_BITS;

   logic            mode_ff;
   logic [Lat-1:0]  vld_ff;
   logic            adv;
   logic            out_vld_ff;
   logic [NoiseWidth-1:0] out_ff, out_in;
   logic [RW-1:0]   root_sel;

   // Stalling happens only when the output is full and not being taken.
   assign adv = !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else if (csr_wen) begin
         mode_ff <= csr_wdata;
      end
   end

   // Cell index and fraction.
   logic [31:0] cx_ff, cy_ff;
   logic [FRAC_BITS-1:0] fx_ff, fy_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff <= 32'($signed(req_tdata[31:0]) >>> FRAC_BITS);
         cy_ff <= 32'($signed(req_tdata[63:32]) >>> FRAC_BITS);
         fx_ff <= req_tdata[FRAC_BITS-1:0];
         fy_ff <= req_tdata[32 +: FRAC_BITS];
      end
   end

   // Fractions delayed across the hash stages.
   logic [FRAC_BITS-1:0] fxd_ff [HashLat];
   logic [FRAC_BITS-1:0] fyd_ff [HashLat];
   always_ff @(posedge clock) begin
      if (adv) begin
         fxd_ff[0] <= fx_ff;
         fyd_ff[0] <= fy_ff;
         for (int i = 1; i < HashLat; i++) begin
            fxd_ff[i] <= fxd_ff[i-1];
            fyd_ff[i] <= fyd_ff[i-1];
         end
      end
   end

   logic [FRAC_BITS-1:0] hx [NumCells];
   logic [FRAC_BITS-1:0] hy [NumCells];
   for (genvar c = 0; c < NumCells; c++) begin : g_hash
      localparam logic [31:0] DU = 32'((c % 3) - 1);
      localparam logic [31:0] DV = 32'((c / 3) - 1);
      cnz_hash #(.FRAC_BITS(FRAC_BITS)) u_hx (
         .clock(clock), .enable(adv),
         .cell_x(cx_ff + DU), .cell_y(cy_ff + DV), .hash_frac(hx[c]));
      cnz_hash #(.FRAC_BITS(FRAC_BITS)) u_hy (
         .clock(clock), .enable(adv),
         .cell_x(cx_ff + DU + OffsetX2), .cell_y(cy_ff + DV + OffsetY2),
         .hash_frac(hy[c]));
   end

   logic [SW-1:0] f1, f2;
   cnz_sort #(.FRAC_BITS(FRAC_BITS)) u_sort (
      .clock(clock), .enable(adv),
      .frac_x(fxd_ff[HashLat-1]), .frac_y(fyd_ff[HashLat-1]),
      .hash_x(hx), .hash_y(hy), .dist_f1(f1), .dist_f2(f2));

   logic [RW-1:0] s1, s2;
   cnz_sqrt #(.IN_W(SW), .OUT_W(RW)) u_sqrt1 (
      .clock(clock), .enable(adv), .radicand(f1), .root(s1));
   cnz_sqrt #(.IN_W(SW), .OUT_W(RW)) u_sqrt2 (
      .clock(clock), .enable(adv), .radicand(f2), .root(s2));

   // The user keeps the mode register stable while items are in flight; the block
   // does not enforce it. A value too wide for the output saturates to all ones.
   always_comb begin
      if (!mode_ff) begin
         root_sel = (s1 > OneVal) ? OneVal : s1;
      end else begin
         root_sel = (s2 > s1) ? s2 - s1 : '0;
      end
      out_in = ((root_sel >> NoiseWidth) != '0) ? '1 : NoiseWidth'(root_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[Lat-2:0], req_tvalid};
         out_vld_ff <= vld_ff[Lat-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {6'b0, out_ff};
endmodule
`default_nettype wire
